### rtl/acws_pkg.sv
// Shared types, codes and constants of the ADC channel window statistics block.
`timescale 1ns / 1ps
`default_nettype none
package acws_pkg;

  localparam int CHANNELS_DEF      = 8;
  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int CMD_W    = 2;
  localparam int CH_W     = 3;
  localparam int SAMPLE_W = 8;
  localparam int KIND_W   = 3;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'hFF;

  // The average quotient is at most eight bits wide.
  localparam int             QUO_W   = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_RST_MAX = 2'd2,
    CMD_RST_MIN = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    Q_CURRENT = 3'd0,
    Q_WIN_AVG = 3'd1,
    Q_WIN_MAX = 3'd2,
    Q_WIN_MIN = 3'd3,
    Q_MAX_ALL = 3'd4,
    Q_MIN_ALL = 3'd5
  } query_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_DRAIN,
    ST_DIVIDE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic exec;
    logic walk_step;
    logic div_step;
    logic result_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_query;
    logic need_walk;
    logic is_avg;
    logic walk_last;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

### rtl/acws_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module acws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

### rtl/acws_ctrl.sv
// Controller state machine: sequences clearing, item execution, window walk and division.
`timescale 1ns / 1ps
`default_nettype none
module acws_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire acws_pkg::ctl_sts_t sts_i,
  output acws_pkg::ctl_cmd_t      cmd_o
);

  acws_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acws_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      acws_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = acws_pkg::ST_IDLE;
        end
      end
      acws_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = acws_pkg::ST_EXEC;
        end
      end
      acws_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (!sts_i.is_query) begin
          state_d = acws_pkg::ST_IDLE;
        end else if (sts_i.need_walk) begin
          state_d = acws_pkg::ST_WALK;
        end else begin
          state_d = acws_pkg::ST_RESULT;
        end
      end
      acws_pkg::ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_last) begin
          state_d = acws_pkg::ST_DRAIN;
        end
      end
      acws_pkg::ST_DRAIN: begin
        // The last ring read lands here and is folded into the accumulators.
        state_d = sts_i.is_avg ? acws_pkg::ST_DIVIDE : acws_pkg::ST_RESULT;
      end
      acws_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        state_d        = acws_pkg::ST_RESULT;
      end
      acws_pkg::ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = acws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = acws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/acws_dp.sv
// Datapath: per-channel registers, sample ring memory, window accumulators, divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module acws_dp #(
  parameter int CHANNELS      = acws_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = acws_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire acws_pkg::ctl_cmd_t              cmd_i,
  output acws_pkg::ctl_sts_t                   sts_o,
  input  wire logic [acws_pkg::CMD_W-1:0]      in_command_i,
  input  wire logic [acws_pkg::CH_W-1:0]       in_channel_i,
  input  wire logic [acws_pkg::SAMPLE_W-1:0]   in_sample_i,
  input  wire logic [acws_pkg::KIND_W-1:0]     in_kind_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [acws_pkg::SAMPLE_W-1:0]   out_value_o,
  output logic                                 out_bad_o
);

  localparam int RAM_DEPTH = CHANNELS * HISTORY_DEPTH;
  localparam int ADDR_W    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int CH_IW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W     = $clog2(HISTORY_DEPTH);
  localparam int SUM_W     = acws_pkg::SAMPLE_W + IDX_W;
  localparam int SW        = acws_pkg::SAMPLE_W;

  // The average is the window sum times a rounded-up reciprocal of the depth,
  // shifted down; the shift is wide enough to be exact for every SUM_W-bit sum.
  localparam int RECIP_SH = SUM_W + IDX_W;
  localparam int RECIP_W  = SUM_W + 1;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((longint'(1) << RECIP_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  // Item registers.
  acws_pkg::cmd_e             cmd_q;
  logic [acws_pkg::CH_W-1:0]   ch_q;
  logic [SW-1:0]               smp_q;
  logic [acws_pkg::KIND_W-1:0] kind_q;

  // Per-channel state.
  logic [IDX_W-1:0] wr_idx_q [CHANNELS];
  logic [SW-1:0]    cur_q    [CHANNELS];
  logic [SW-1:0]    hi_q     [CHANNELS];
  logic [SW-1:0]    lo_q     [CHANNELS];

  logic [ADDR_W-1:0]  clr_q;
  logic [IDX_W-1:0]   walk_q;
  logic               rd_vld_q;
  logic [SUM_W-1:0]   acc_q;
  logic [SW-1:0]      wmax_q;
  logic [SW-1:0]      wmin_q;
  logic [acws_pkg::QUO_W-1:0] quo_q;

  logic               present;
  logic [CH_IW-1:0]   ch_idx;
  logic [ADDR_W-1:0]  base;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [SW-1:0]      ram_wdata;
  logic [SW-1:0]      ram_rdata;
  logic               do_sample;
  logic [PROD_W-1:0]  avg_prod;
  logic [SW-1:0]      res_value;
  logic               res_bad;
  logic               out_valid_q;
  logic [SW-1:0]      out_value_q;
  logic               out_bad_q;

  assign present = int'(ch_q) < CHANNELS;
  assign ch_idx  = CH_IW'(ch_q);
  assign base    = ADDR_W'(int'(ch_idx) * HISTORY_DEPTH);
  assign do_sample = cmd_i.exec && present && (cmd_q == acws_pkg::CMD_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= acws_pkg::cmd_e'(in_command_i);
      ch_q   <= in_channel_i;
      smp_q  <= in_sample_i;
      kind_q <= in_kind_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_idx_q[i] <= '0;
        cur_q[i]    <= '0;
        hi_q[i]     <= '0;
        lo_q[i]     <= acws_pkg::FULL_SCALE;
      end
    end else if (cmd_i.exec && present) begin
      case (cmd_q)
        acws_pkg::CMD_SAMPLE: begin
          cur_q[ch_idx] <= smp_q;
          if (smp_q > hi_q[ch_idx]) begin
            hi_q[ch_idx] <= smp_q;
          end
          if (smp_q < lo_q[ch_idx]) begin
            lo_q[ch_idx] <= smp_q;
          end
          if (wr_idx_q[ch_idx] == IDX_W'(HISTORY_DEPTH - 1)) begin
            wr_idx_q[ch_idx] <= '0;
          end else begin
            wr_idx_q[ch_idx] <= wr_idx_q[ch_idx] + 1'b1;
          end
        end
        acws_pkg::CMD_RST_MAX: hi_q[ch_idx] <= '0;
        acws_pkg::CMD_RST_MIN: lo_q[ch_idx] <= acws_pkg::FULL_SCALE;
        default: ;
      endcase
    end
  end

  // The clearing pass zeroes the ring one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.walk_step;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_comb begin
    ram_we    = cmd_i.clear_step || do_sample;
    ram_wdata = cmd_i.clear_step ? '0 : smp_q;
    if (cmd_i.clear_step) begin
      ram_addr = clr_q;
    end else if (cmd_i.walk_step) begin
      ram_addr = base + ADDR_W'(walk_q);
    end else begin
      ram_addr = base + ADDR_W'(wr_idx_q[ch_idx]);
    end
  end

  acws_ram #(
    .WIDTH (SW),
    .DEPTH (RAM_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign avg_prod = PROD_W'(acc_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      walk_q <= '0;
      acc_q  <= '0;
      wmax_q <= '0;
      wmin_q <= acws_pkg::FULL_SCALE;
      quo_q  <= '0;
    end else begin
      if (cmd_i.walk_step) begin
        walk_q <= walk_q + 1'b1;
      end
      if (rd_vld_q) begin
        acc_q <= acc_q + SUM_W'(ram_rdata);
        if (ram_rdata > wmax_q) begin
          wmax_q <= ram_rdata;
        end
        if (ram_rdata < wmin_q) begin
          wmin_q <= ram_rdata;
        end
      end
      if (cmd_i.div_step) begin
        quo_q <= acws_pkg::QUO_W'(avg_prod >> RECIP_SH);
      end
    end
  end

  always_comb begin
    res_value = '0;
    res_bad   = 1'b0;
    if (!present) begin
      res_bad = 1'b1;
    end else begin
      case (kind_q)
        acws_pkg::Q_CURRENT: res_value = cur_q[ch_idx];
        acws_pkg::Q_WIN_AVG: res_value = quo_q;
        acws_pkg::Q_WIN_MAX: res_value = wmax_q;
        acws_pkg::Q_WIN_MIN: res_value = wmin_q;
        acws_pkg::Q_MAX_ALL: res_value = hi_q[ch_idx];
        acws_pkg::Q_MIN_ALL: res_value = lo_q[ch_idx];
        default:             res_bad   = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_value_q <= res_value;
      out_bad_q   <= res_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_bad_o   = out_bad_q;

  always_comb begin
    sts_o            = '0;
    sts_o.clear_done = clr_q == ADDR_W'(RAM_DEPTH - 1);
    sts_o.is_query   = cmd_q == acws_pkg::CMD_QUERY;
    sts_o.need_walk  = present && ((kind_q == acws_pkg::Q_WIN_AVG) ||
                                   (kind_q == acws_pkg::Q_WIN_MAX) ||
                                   (kind_q == acws_pkg::Q_WIN_MIN));
    sts_o.is_avg     = kind_q == acws_pkg::Q_WIN_AVG;
    sts_o.walk_last  = walk_q == IDX_W'(HISTORY_DEPTH - 1);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

### rtl/adc_channel_window_statistics.sv
// Top level of the ADC channel window statistics block.
//
// Items arrive on the slave stream: tuser carries the command and the query kind,
// tdata the channel and the sample. Sample items update the channel's current value,
// running peaks and ring of the HISTORY_DEPTH latest samples; reset items restore a
// peak. Only query items produce a result item on the master stream: tdata holds the
// value, tuser the bad-query flag.
// The block works on one item at a time; tready is high only when it is free.
// Steps per item, from acceptance until the next item can be taken:
//   sample and peak reset items: execute,
//   current value and peak queries: execute, result,
//   window max and min: execute, ring walk (one ring read per cycle), drain, result,
//   window average: execute, ring walk, drain, reciprocal multiplication, result.
// A result sits in an output register; a new item is taken while it waits, and a
// further result waits only until the receiver takes the earlier one.
// After reset the ring memory is cleared one entry per cycle, all
// CHANNELS * HISTORY_DEPTH entries, during which tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module adc_channel_window_statistics #(
  parameter int CHANNELS      = acws_pkg::CHANNELS_DEF,
  parameter int HISTORY_DEPTH = acws_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // channel [2:0], sample [10:3], zero [15:11]
  input  wire logic [4:0]  s_axis_tuser_i,  // command [1:0], query_kind [4:2]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [7:0]  m_axis_tdata_o,  // value [7:0]
  output logic      [0:0]  m_axis_tuser_o   // bad_query [0]
);

  acws_pkg::ctl_cmd_t cmd;
  acws_pkg::ctl_sts_t sts;

  acws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  acws_dp #(
    .CHANNELS      (CHANNELS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_command_i (s_axis_tuser_i[1:0]),
    .in_channel_i (s_axis_tdata_i[2:0]),
    .in_sample_i  (s_axis_tdata_i[10:3]),
    .in_kind_i    (s_axis_tuser_i[4:2]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_value_o  (m_axis_tdata_o),
    .out_bad_o    (m_axis_tuser_o[0])
  );

endmodule
`default_nettype wire

### tb/adc_channel_window_statistics_tb.sv
// Self-checking testbench for the ADC channel window statistics block.
`timescale 1ns / 1ps
module adc_channel_window_statistics_tb;
  import acws_pkg::*;

  localparam int NUM_CH      = 8;
  localparam int RING_DEPTH  = 8;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 5_000_000;

  typedef struct packed {
    cmd_e       cmd;
    logic [2:0] ch;
    logic [7:0] sample;
    logic [2:0] kind;
  } adc_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic       bad;
  } stat_answer_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_JITTER,
    RX_HOLD
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // channel [2:0], sample [10:3], zero [15:11]
  logic [4:0]  s_tuser = '0;  // command [1:0], query_kind [4:2]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;       // value [7:0]
  logic [0:0]  m_tuser;       // bad_query [0]

  adc_channel_window_statistics uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Expected per-channel statistics.
  logic [7:0] hist_ring [NUM_CH][RING_DEPTH];
  int         hist_wr   [NUM_CH];
  logic [7:0] cur_val   [NUM_CH];
  logic [7:0] peak_hi   [NUM_CH];
  logic [7:0] peak_lo   [NUM_CH];

  adc_item_t    items_to_send [$];
  stat_answer_t answers_due   [$];
  adc_item_t    offered;
  int           errors = 0;
  int           cycle_count = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic add_item(input cmd_e cmd, input int ch, input int sample, input int kind);
    adc_item_t it;
    it.cmd    = cmd;
    it.ch     = ch[2:0];
    it.sample = sample[7:0];
    it.kind   = kind[2:0];
    items_to_send.push_back(it);
  endtask

  // Updates the expected statistics with one accepted item and queues the
  // answer that a query must produce.
  task automatic apply_to_stats(input adc_item_t it);
    stat_answer_t ans;
    int           acc;
    int           c;
    c = it.ch;
    case (it.cmd)
      CMD_SAMPLE: begin
        cur_val[c] = it.sample;
        if (it.sample > peak_hi[c]) peak_hi[c] = it.sample;
        if (it.sample < peak_lo[c]) peak_lo[c] = it.sample;
        hist_ring[c][hist_wr[c]] = it.sample;
        hist_wr[c] = (hist_wr[c] + 1) % RING_DEPTH;
      end
      CMD_RST_MAX: peak_hi[c] = 8'd0;
      CMD_RST_MIN: peak_lo[c] = 8'd255;
      default: begin
        ans.bad   = 1'b0;
        ans.value = 8'd0;
        case (it.kind)
          Q_CURRENT: ans.value = cur_val[c];
          Q_WIN_AVG: begin
            acc = 0;
            for (int k = 0; k < RING_DEPTH; k++) acc += hist_ring[c][k];
            ans.value = 8'(acc / RING_DEPTH);
          end
          Q_WIN_MAX: begin
            acc = 0;
            for (int k = 0; k < RING_DEPTH; k++)
              if (hist_ring[c][k] > acc) acc = hist_ring[c][k];
            ans.value = 8'(acc);
          end
          Q_WIN_MIN: begin
            acc = 255;
            for (int k = 0; k < RING_DEPTH; k++)
              if (hist_ring[c][k] < acc) acc = hist_ring[c][k];
            ans.value = 8'(acc);
          end
          Q_MAX_ALL: ans.value = peak_hi[c];
          Q_MIN_ALL: ans.value = peak_lo[c];
          default:   ans.bad = 1'b1;
        endcase
        answers_due.push_back(ans);
      end
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps. An offered
  // item is held until the block takes it.
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk_i) begin
    logic fire;
    logic show;
    if (rst_ni) begin
      fire = s_tvalid && s_tready;
      if (fire) apply_to_stats(offered);
      if (!s_tvalid || fire) begin
        show = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (items_to_send.size() > 0) begin
          offered = items_to_send.pop_front();
          show = 1'b1;
          s_tdata <= {5'b0, offered.sample, offered.ch};
          s_tuser <= {offered.kind, offered.cmd};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            case ($urandom_range(0, 9))
              0, 1, 2: gap_left = 0;
              9:       gap_left = $urandom_range(20, 60);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end
        end
        s_tvalid <= show;
      end
    end
  end

  // Receiver: free-running, jittered and long hold-off phases. The first
  // hold-off is forced so the output register fills and the input stalls.
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left = 0;
  logic     held_once = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_left == 0) begin
        if ((!held_once && cycle_count > 2000) || $urandom_range(0, 11) == 0) begin
          rx_mode = RX_HOLD;
          rx_left = $urandom_range(300, 600);
          held_once = 1'b1;
        end else begin
          rx_mode = ($urandom_range(0, 1) == 0) ? RX_FREE : RX_JITTER;
          rx_left = $urandom_range(20, 200);
        end
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_JITTER: m_tready <= ($urandom_range(0, 2) != 0);
        default:   m_tready <= 1'b0;
      endcase
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    stat_answer_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result with none expected: value %0d bad %0d",
                                  m_tdata, m_tuser));
      end else begin
        want = answers_due.pop_front();
        if (m_tdata !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d", m_tdata, want.value));
        if (m_tuser[0] !== want.bad)
          report_mismatch($sformatf("bad_query %0d, expected %0d", m_tuser, want.bad));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** adc_channel_window_statistics: FAILED **");
      $finish;
    end
  end

  initial begin
    int r;
    adc_item_t it;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < RING_DEPTH; k++) hist_ring[c][k] = 8'd0;
      hist_wr[c] = 0;
      cur_val[c] = 8'd0;
      peak_hi[c] = 8'd0;
      peak_lo[c] = 8'd255;
    end

    // Fresh channel: the minimum since reset is full scale, the window
    // minimum sees the unwritten zero slots.
    add_item(CMD_QUERY, 3, 8'hA5, Q_MIN_ALL);
    add_item(CMD_QUERY, 3, 8'h5A, Q_WIN_MIN);
    add_item(CMD_QUERY, 3, 0, Q_WIN_AVG);
    add_item(CMD_SAMPLE, 0, 255, 7);
    add_item(CMD_SAMPLE, 0, 0, 0);
    add_item(CMD_SAMPLE, 7, 200, 5);
    // Every query kind, the two unknown ones included, on a partly filled ring.
    for (int k = 0; k < 8; k++) add_item(CMD_QUERY, 0, 255 - k, k);
    add_item(CMD_SAMPLE, 7, 255, 2);
    add_item(CMD_QUERY, 7, 0, Q_WIN_AVG);
    add_item(CMD_QUERY, 7, 0, Q_WIN_MAX);
    add_item(CMD_RST_MAX, 0, 255, 7);
    add_item(CMD_RST_MIN, 0, 0, 7);
    add_item(CMD_QUERY, 0, 0, Q_MAX_ALL);
    add_item(CMD_QUERY, 0, 0, Q_MIN_ALL);
    add_item(CMD_QUERY, 7, 0, 7);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      it.cmd = CMD_SAMPLE;
      else if (r < 80) it.cmd = CMD_QUERY;
      else if (r < 90) it.cmd = CMD_RST_MAX;
      else             it.cmd = CMD_RST_MIN;
      it.ch = 3'($urandom_range(0, NUM_CH - 1));
      case ($urandom_range(0, 9))
        0:       it.sample = 8'd0;
        1:       it.sample = 8'd255;
        default: it.sample = 8'($urandom_range(0, 255));
      endcase
      it.kind = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 5))
                                             : 3'($urandom_range(6, 7));
      items_to_send.push_back(it);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_to_send.size() > 0 || s_tvalid || answers_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0)
      $display("** adc_channel_window_statistics: PASSED **");
    else
      $display("** adc_channel_window_statistics: FAILED **");
    $finish;
  end

endmodule
